/* src/lzse_pkg.sv */
// shared types and constants of the lz sequence executor
package lzse_pkg;

  localparam int DEF_WINDOW_BYTES  = 32768;
  localparam int DEF_LITERAL_BYTES = 131072;
  localparam logic [31:0] CAP_RESET = 32'd131072;
  localparam logic [30:0] REPEAT_SHIFT = 31'd3;

  typedef enum logic [2:0] {
    CMD_HISTORY = 3'd0,
    CMD_LITERAL = 3'd1,
    CMD_SEQUENCE = 3'd2,
    CMD_PULL = 3'd3,
    CMD_END = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_CORRUPT = 2'd1,
    ST_TOO_SMALL = 2'd2
  } status_t;

  typedef struct packed {
    logic hist_wr;
    logic lit_wr;
    logic pull;
    logic src_lit;
  } store_req_t;

endpackage

/* src/lzse_store.sv */
// window and literal memories with write-back and forwarding
module lzse_store #(
  parameter int WINDOW_BYTES  = lzse_pkg::DEF_WINDOW_BYTES,
  parameter int LITERAL_BYTES = lzse_pkg::DEF_LITERAL_BYTES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lzse_pkg::store_req_t             req,
  input  logic [$clog2(WINDOW_BYTES)-1:0]  win_raddr,
  input  logic [$clog2(WINDOW_BYTES)-1:0]  win_waddr,
  input  logic [$clog2(LITERAL_BYTES)-1:0] lit_raddr,
  input  logic [$clog2(LITERAL_BYTES)-1:0] lit_waddr,
  input  logic [7:0]                       wbyte,
  output logic [7:0]                       rd_byte
);
  import lzse_pkg::*;

  localparam int AW = $clog2(WINDOW_BYTES);

  logic [7:0] win_mem [WINDOW_BYTES];
  logic [7:0] lit_mem [LITERAL_BYTES];

  logic [7:0]    win_q_r;
  logic [7:0]    lit_q_r;
  logic          src_lit_r;
  logic          fwd_r;
  logic [7:0]    fwd_byte_r;
  logic          wr_pend_r;
  logic          wr_hist_r;
  logic [AW-1:0] wr_addr_r;
  logic [7:0]    hist_byte_r;
  logic [7:0]    wdata;

  assign rd_byte = src_lit_r ? lit_q_r : (fwd_r ? fwd_byte_r : win_q_r);
  assign wdata   = wr_hist_r ? hist_byte_r : rd_byte;

  always_ff @(posedge clk) begin
    if (req.lit_wr) begin
      lit_mem[lit_waddr] <= wbyte;
    end
    if (req.pull && req.src_lit) begin
      lit_q_r <= lit_mem[lit_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_pend_r) begin
      win_mem[wr_addr_r] <= wdata;
    end
    if (req.pull && !req.src_lit) begin
      win_q_r <= win_mem[win_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.pull) begin
      src_lit_r  <= req.src_lit;
      fwd_r      <= wr_pend_r && (wr_addr_r == win_raddr);
      fwd_byte_r <= wdata;
    end
    if (req.pull || req.hist_wr) begin
      wr_addr_r   <= win_waddr;
      wr_hist_r   <= req.hist_wr;
      hist_byte_r <= wbyte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pend_r <= 1'b0;
    end else begin
      wr_pend_r <= req.pull || req.hist_wr;
    end
  end

endmodule

/* src/lz_sequence_executor.sv */
// lz sequence executor top level: command decode, repeat offsets and checks
// output: a status or output byte is presented in the cycle after its request is accepted
// throughput: one request per cycle, pulls included, while no output waiting on out_tready holds in_tready low
// a match at distance one is served from the pending window write by forwarding
// reset: synchronous active-low rst_n clears counters and errors and sets repeat offsets to 1, 4 and 8
// memory contents are not cleared; capacity returns to 131072
module lz_sequence_executor #(
  parameter int WINDOW_BYTES  = lzse_pkg::DEF_WINDOW_BYTES,
  parameter int LITERAL_BYTES = lzse_pkg::DEF_LITERAL_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // in_byte, lit_len, offset_value, copy_len
  input  logic [2:0]  in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // status, out_byte
  output logic        out_tlast,  // last_of_run
  output logic [0:0]  out_tuser,  // is_status
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);
  import lzse_pkg::*;

  localparam int AW  = $clog2(WINDOW_BYTES);
  localparam int LW  = $clog2(LITERAL_BYTES);
  localparam int LCW = $clog2(LITERAL_BYTES + 1);
  localparam logic [AW+1:0] W_EXT = WINDOW_BYTES[AW+1:0];
  localparam logic [AW-1:0] W_LAST = AW'(WINDOW_BYTES - 1);
  localparam logic [31:0] W_32 = 32'(WINDOW_BYTES);
  localparam logic [LCW-1:0] L_CNT = LCW'(LITERAL_BYTES);

  logic [31:0]    cap_r;
  logic [AW-1:0]  wpos_r, wpos_nxt;
  logic [LCW-1:0] lcnt_r, lcnt_nxt, lpos_r, lpos_nxt;
  logic [31:0]    hcnt_r, hcnt_nxt, wcnt_r, wcnt_nxt;
  logic [31:0]    rep0_r, rep1_r, rep2_r, rep0_nxt, rep1_nxt, rep2_nxt;
  logic [LCW-1:0] plit_r, plit_nxt;
  logic [17:0]    pmat_r, pmat_nxt;
  logic [31:0]    dist_r, dist_nxt;
  logic           erun_r, erun_nxt;
  logic [1:0]     err_r, err_nxt;
  logic           ov_r, ov_nxt;
  logic           ostat_r, ostat_nxt;
  logic [1:0]     ostatus_r, ostatus_nxt;
  logic           olast_r, olast_nxt;

  logic           in_acc, busy, emit;
  cmd_t           cmd;
  logic [7:0]     in_byte;
  logic [16:0]    ll;
  logic [30:0]    ov;
  logic [17:0]    ml;
  store_req_t     req;
  logic [7:0]     rd_byte;
  logic [LCW-1:0] left;
  logic [31:0]    off, d_eff;
  logic [AW+1:0]  rsum;
  logic [AW-1:0]  win_raddr;
  logic [32:0]    w_ll, w_left;
  logic [33:0]    w_ll_ml, w_ll_h;
  logic [1:0]     pick;
  logic           new_off;

  assign in_tready = !ov_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign cmd       = cmd_t'(in_tuser);
  assign in_byte   = in_tdata[7:0];
  assign ll        = in_tdata[24:8];
  assign ov        = in_tdata[55:25];
  assign ml        = in_tdata[73:56];
  assign busy      = (plit_r != '0) || (pmat_r != '0);
  assign left      = lcnt_r - lpos_r;

  assign d_eff     = (dist_r == '0 || dist_r > W_32) ? W_32 : dist_r;
  assign rsum      = {2'b0, wpos_r} + W_EXT - d_eff[AW+1:0];
  assign win_raddr = (rsum >= W_EXT) ? AW'(rsum - W_EXT) : rsum[AW-1:0];

  assign w_ll    = {1'b0, wcnt_r} + 33'(ll);
  assign w_left  = {1'b0, wcnt_r} + 33'(left);
  assign w_ll_ml = {1'b0, w_ll} + 34'(ml);
  assign w_ll_h  = {1'b0, w_ll} + {2'b0, hcnt_r};
  assign new_off = (ov > REPEAT_SHIFT) || (ov == REPEAT_SHIFT && ll == '0);

  always_comb begin
    pick = (ll == '0) ? ov[1:0] : 2'(ov[1:0] - 2'd1);
    if (pick > 2'd2) begin
      pick = 2'd2;
    end
  end

  always_comb begin
    wpos_nxt = wpos_r;  lcnt_nxt = lcnt_r;  lpos_nxt = lpos_r;
    hcnt_nxt = hcnt_r;  wcnt_nxt = wcnt_r;
    rep0_nxt = rep0_r;  rep1_nxt = rep1_r;  rep2_nxt = rep2_r;
    plit_nxt = plit_r;  pmat_nxt = pmat_r;  dist_nxt = dist_r;
    erun_nxt = erun_r;  err_nxt = err_r;
    emit = 1'b0;  ostat_nxt = ostat_r;  ostatus_nxt = ostatus_r;  olast_nxt = olast_r;
    req = '0;
    off = '0;
    if (in_acc) begin
      unique case (cmd)
        CMD_HISTORY: begin
          if (err_r == '0 && !busy) begin
            req.hist_wr = 1'b1;
            wpos_nxt = (wpos_r == W_LAST) ? '0 : wpos_r + 1'b1;
            if (hcnt_r != '1) begin
              hcnt_nxt = hcnt_r + 1'b1;
            end
          end
        end
        CMD_LITERAL: begin
          if (err_r == '0 && !erun_r && lcnt_r < L_CNT) begin
            req.lit_wr = 1'b1;
            lcnt_nxt = lcnt_r + 1'b1;
          end
        end
        CMD_SEQUENCE, CMD_END: begin
          emit = 1'b1;  ostat_nxt = 1'b1;  olast_nxt = 1'b0;
          ostatus_nxt = ST_OK;
          if (err_r != '0) begin
            ostatus_nxt = err_r;
          end else if (busy) begin
            ostatus_nxt = ST_CORRUPT;
          end else if (cmd == CMD_END) begin
            if (w_left > {1'b0, cap_r}) begin
              ostatus_nxt = ST_TOO_SMALL;
            end else if (left == '0) begin
              lcnt_nxt = '0;  lpos_nxt = '0;
            end else begin
              plit_nxt = left;  erun_nxt = 1'b1;
            end
          end else if (ov == '0) begin
            ostatus_nxt = ST_CORRUPT;
          end else begin
            if (new_off) begin
              off = (ov > REPEAT_SHIFT) ? {1'b0, ov - REPEAT_SHIFT} : rep0_r - 1'b1;
            end else begin
              unique case (pick)
                2'd0:    off = rep0_r;
                2'd1:    off = rep1_r;
                default: off = rep2_r;
              endcase
            end
            if (off == '0) begin
              ostatus_nxt = ST_CORRUPT;
            end else begin
              rep0_nxt = off;
              if (new_off || pick != 2'd0) begin
                rep1_nxt = rep0_r;
              end
              if (new_off || pick == 2'd2) begin
                rep2_nxt = rep1_r;
              end
              if (33'(ll) > 33'(left)) begin
                ostatus_nxt = ST_CORRUPT;
              end else if (w_ll > {1'b0, cap_r}) begin
                ostatus_nxt = ST_TOO_SMALL;
              end else if ({2'b0, off} > w_ll_h || off > W_32) begin
                ostatus_nxt = ST_CORRUPT;
              end else if (w_ll_ml > {2'b0, cap_r}) begin
                ostatus_nxt = ST_TOO_SMALL;
              end else begin
                plit_nxt = LCW'(ll);  pmat_nxt = ml;  dist_nxt = off;
              end
            end
          end
          if (err_r == '0 && !busy && ostatus_nxt != ST_OK) begin
            err_nxt = ostatus_nxt;
          end
        end
        CMD_PULL: begin
          if (err_r == '0 && busy) begin
            emit = 1'b1;  ostat_nxt = 1'b0;  ostatus_nxt = ST_OK;
            req.pull = 1'b1;
            if (plit_r != '0) begin
              req.src_lit = 1'b1;
              lpos_nxt = lpos_r + 1'b1;
              plit_nxt = plit_r - 1'b1;
            end else begin
              pmat_nxt = pmat_r - 1'b1;
            end
            wpos_nxt = (wpos_r == W_LAST) ? '0 : wpos_r + 1'b1;
            wcnt_nxt = wcnt_r + 1'b1;
            olast_nxt = (plit_nxt == '0) && (pmat_nxt == '0);
            if (olast_nxt && erun_r) begin
              erun_nxt = 1'b0;  lcnt_nxt = '0;  lpos_nxt = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (emit) begin
      ov_nxt = 1'b1;
    end else begin
      ov_nxt = ov_r && !out_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
      wpos_r <= '0;  lcnt_r <= '0;  lpos_r <= '0;  hcnt_r <= '0;  wcnt_r <= '0;
      rep0_r <= 32'd1;  rep1_r <= 32'd4;  rep2_r <= 32'd8;
      plit_r <= '0;  pmat_r <= '0;  dist_r <= '0;  erun_r <= 1'b0;  err_r <= '0;
      ov_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      wpos_r <= wpos_nxt;  lcnt_r <= lcnt_nxt;  lpos_r <= lpos_nxt;
      hcnt_r <= hcnt_nxt;  wcnt_r <= wcnt_nxt;
      rep0_r <= rep0_nxt;  rep1_r <= rep1_nxt;  rep2_r <= rep2_nxt;
      plit_r <= plit_nxt;  pmat_r <= pmat_nxt;  dist_r <= dist_nxt;
      erun_r <= erun_nxt;  err_r <= err_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ostat_r <= ostat_nxt;
    ostatus_r <= ostatus_nxt;
    olast_r <= olast_nxt;
  end

  lzse_store #(
    .WINDOW_BYTES(WINDOW_BYTES),
    .LITERAL_BYTES(LITERAL_BYTES)
  ) u_store (
    .clk(clk),
    .rst_n(rst_n),
    .req(req),
    .win_raddr(win_raddr),
    .win_waddr(wpos_r),
    .lit_raddr(lpos_r[LW-1:0]),
    .lit_waddr(lcnt_r[LW-1:0]),
    .wbyte(in_byte),
    .rd_byte(rd_byte)
  );

  assign out_tvalid = ov_r;
  assign out_tuser  = ostat_r;
  assign out_tlast  = ostat_r ? 1'b0 : olast_r;
  assign out_tdata  = {6'b0, (ostat_r ? 8'h00 : rd_byte), (ostat_r ? ostatus_r : ST_OK)};

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != '0) |=> (err_r == $past(err_r)))
    else $error("sticky error changed");

  a_erun_pending: assert property (@(posedge clk) disable iff (!rst_n)
    erun_r |-> (plit_r != '0 && pmat_r == '0))
    else $error("end run without pending literals");

  a_lit_order: assert property (@(posedge clk) disable iff (!rst_n)
    lpos_r <= lcnt_r)
    else $error("literal position beyond count");

  a_pull_result: assert property (@(posedge clk) disable iff (!rst_n)
    req.pull |=> (out_tvalid && !ostat_r))
    else $error("pull gave no byte");

endmodule
